// ===== rtl/dvrt_pkg.sv =====
// shared types, constants and helpers of the distance-vector route table
package dvrt_pkg;

  localparam int unsigned TableEntries = 32;
  localparam int unsigned AddrW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  localparam logic [15:0] InfCost = 16'hFFFF;
  localparam logic [1:0] MissLimit = 2'd2;
  localparam logic [1:0] MissMax = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ADVERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_DUMP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RELAX,
    ST_ADV_RESULT,
    ST_WALK
  } state_e;

  typedef struct packed {
    logic [15:0] dest_id;
    logic [15:0] hop_cost;
    logic [15:0] best_cost;
    logic [15:0] gw_id;
    logic        is_neighbor;
    logic [1:0]  missed;
  } row_t;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    row_t             wr_data;
  } ram_req_t;

  typedef struct packed {
    logic [5:0]  row_index;
    logic [15:0] row_node_id;
    logic [15:0] row_next_hop;
    logic [15:0] row_path_cost;
    logic        send_to_row;
    logic        entry_changed;
    logic        send_update_now;
    logic        sender_unknown;
    logic        last_result;
  } res_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? InfCost : s[15:0];
  endfunction

endpackage

// ===== rtl/dvrt_if.sv =====
// channel interfaces: input items, result items and configuration writes
interface dvrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  entry_index;
  logic [15:0] node_id;
  logic [15:0] cost;
  logic [15:0] sender_id;
  logic        last_in_advert;

  modport source (
    output valid, operation, entry_index, node_id, cost, sender_id, last_in_advert,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, node_id, cost, sender_id, last_in_advert,
    output ready
  );
endinterface

interface dvrt_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  row_index;
  logic [15:0] row_node_id;
  logic [15:0] row_next_hop;
  logic [15:0] row_path_cost;
  logic        send_to_row;
  logic        entry_changed;
  logic        send_update_now;
  logic        sender_unknown;
  logic        last_result;

  modport source (
    output valid, row_index, row_node_id, row_next_hop, row_path_cost, send_to_row,
           entry_changed, send_update_now, sender_unknown, last_result,
    input  ready
  );
  modport sink (
    input  valid, row_index, row_node_id, row_next_hop, row_path_cost, send_to_row,
           entry_changed, send_update_now, sender_unknown, last_result,
    output ready
  );
endinterface

interface dvrt_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] node_count;

  modport source (output valid, node_count, input ready);
  modport sink (input valid, node_count, output ready);
endinterface

// ===== rtl/dvrt_table_ram.sv =====
// route table memory: one write port, one read port, registered read data
module dvrt_table_ram (
  input  logic                clk_i,
  input  dvrt_pkg::ram_req_t  req_i,
  output dvrt_pkg::row_t      rd_data_o
);

  dvrt_pkg::row_t mem [dvrt_pkg::TableEntries];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.rd_addr];
    end
  end

endmodule

// ===== rtl/dvrt_ctrl.sv =====
// table sequencer: load, sender search, relaxation walk, tick and dump walks
module dvrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  dvrt_in_if.sink            in_ch,
  input  logic [6:0]         node_count_i,
  input  logic               out_free_i,
  output logic               res_valid_o,
  output dvrt_pkg::res_t     res_o,
  output dvrt_pkg::ram_req_t ram_req_o,
  input  dvrt_pkg::row_t     ram_rd_data_i
);

  localparam int unsigned AW = dvrt_pkg::AddrW;
  localparam int unsigned CW = dvrt_pkg::CntW;

  dvrt_pkg::state_e state_q, state_d;

  logic [CW-1:0] n_rows;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic          dv_q, dv_d;
  logic [AW-1:0] dat_row_q, dat_row_d;
  logic [AW-1:0] snd_row_q, snd_row_d;
  logic [15:0]   sid_q, sid_d;
  logic [15:0]   nid_q, nid_d;
  logic [15:0]   cost_q, cost_d;
  logic [15:0]   sum_q, sum_d;
  logic          last_q, last_d;
  logic          tick_q, tick_d;
  logic          found_q, found_d;
  logic          hit_q, hit_d;
  logic          chg_q, chg_d;
  logic          pending_q, pending_d;
  logic [AW-1:0] first_row_q, first_row_d;
  dvrt_pkg::row_t first_rec_q, first_rec_d;

  logic           in_acc;
  logic           more;
  logic           match;
  logic           walk_take;
  logic           send;
  logic           now;
  dvrt_pkg::op_e  op;
  dvrt_pkg::row_t r;

  assign n_rows = (node_count_i > 7'(dvrt_pkg::TableEntries)) ?
                  CW'(dvrt_pkg::TableEntries) : CW'(node_count_i);
  assign in_ch.ready = (state_q == dvrt_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign op          = dvrt_pkg::op_e'(in_ch.operation);
  assign more        = (rd_ptr_q < n_rows);
  assign match       = dv_q && (ram_rd_data_i.dest_id == sid_q);
  assign walk_take   = dv_q && out_free_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dvrt_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            dvrt_pkg::OP_ADVERT: state_d = dvrt_pkg::ST_SEARCH;
            dvrt_pkg::OP_TICK,
            dvrt_pkg::OP_DUMP:   state_d = dvrt_pkg::ST_WALK;
            default:             state_d = dvrt_pkg::ST_IDLE;
          endcase
        end
      end
      dvrt_pkg::ST_SEARCH: begin
        if (match) begin
          state_d = dvrt_pkg::ST_RELAX;
        end else if (!more) begin
          state_d = dvrt_pkg::ST_ADV_RESULT;
        end
      end
      dvrt_pkg::ST_RELAX: begin
        if (!more) begin
          state_d = dvrt_pkg::ST_ADV_RESULT;
        end
      end
      dvrt_pkg::ST_ADV_RESULT: begin
        if (out_free_i) begin
          state_d = dvrt_pkg::ST_IDLE;
        end
      end
      dvrt_pkg::ST_WALK: begin
        if (!more && (!dv_q || out_free_i)) begin
          state_d = dvrt_pkg::ST_IDLE;
        end
      end
      default: state_d = dvrt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    dv_d        = dv_q;
    dat_row_d   = dat_row_q;
    snd_row_d   = snd_row_q;
    sid_d       = sid_q;
    nid_d       = nid_q;
    cost_d      = cost_q;
    sum_d       = sum_q;
    last_d      = last_q;
    tick_d      = tick_q;
    found_d     = found_q;
    hit_d       = hit_q;
    chg_d       = chg_q;
    pending_d   = pending_q;
    first_row_d = first_row_q;
    first_rec_d = first_rec_q;
    ram_req_o   = '0;
    res_valid_o = 1'b0;
    res_o       = '0;
    r           = ram_rd_data_i;
    send        = 1'b0;
    now         = 1'b0;

    case (state_q)
      dvrt_pkg::ST_IDLE: begin
        if (in_acc) begin
          sid_d    = in_ch.sender_id;
          nid_d    = in_ch.node_id;
          cost_d   = in_ch.cost;
          last_d   = in_ch.last_in_advert;
          tick_d   = (op == dvrt_pkg::OP_TICK);
          rd_ptr_d = '0;
          dv_d     = 1'b0;
          found_d  = 1'b0;
          hit_d    = 1'b0;
          chg_d    = 1'b0;
          if (op == dvrt_pkg::OP_LOAD &&
              {1'b0, in_ch.entry_index} < 7'(dvrt_pkg::TableEntries)) begin
            ram_req_o.wr_en             = 1'b1;
            ram_req_o.wr_addr           = AW'(in_ch.entry_index);
            ram_req_o.wr_data.dest_id   = in_ch.node_id;
            ram_req_o.wr_data.hop_cost  = in_ch.cost;
            ram_req_o.wr_data.best_cost = in_ch.cost;
            ram_req_o.wr_data.missed    = '0;
            ram_req_o.wr_data.gw_id     = (in_ch.cost == dvrt_pkg::InfCost) ?
                                          dvrt_pkg::InfCost : in_ch.node_id;
            ram_req_o.wr_data.is_neighbor = (in_ch.cost != '0) &&
                                            (in_ch.cost != dvrt_pkg::InfCost);
          end
        end
      end

      dvrt_pkg::ST_SEARCH: begin
        if (match) begin
          found_d   = 1'b1;
          snd_row_d = dat_row_q;
          sum_d     = dvrt_pkg::sat_add(cost_q, ram_rd_data_i.hop_cost);
          rd_ptr_d  = '0;
          dv_d      = 1'b0;
        end else begin
          dv_d = more;
          if (more) begin
            ram_req_o.rd_en   = 1'b1;
            ram_req_o.rd_addr = rd_ptr_q[AW-1:0];
            dat_row_d         = rd_ptr_q[AW-1:0];
            rd_ptr_d          = rd_ptr_q + CW'(1);
          end
        end
      end

      dvrt_pkg::ST_RELAX: begin
        if (dv_q) begin
          if (dat_row_q == snd_row_q) begin
            r.missed = '0;
          end
          if (r.dest_id == nid_q) begin
            if (r.gw_id == sid_q) begin
              r.best_cost = sum_q;
            end else if (r.best_cost > sum_q) begin
              r.best_cost = sum_q;
              r.gw_id     = sid_q;
              chg_d       = 1'b1;
            end
            if (!hit_q) begin
              hit_d       = 1'b1;
              first_row_d = dat_row_q;
              first_rec_d = r;
            end
          end
          ram_req_o.wr_en   = 1'b1;
          ram_req_o.wr_addr = dat_row_q;
          ram_req_o.wr_data = r;
        end
        dv_d = more;
        if (more) begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = rd_ptr_q[AW-1:0];
          dat_row_d         = rd_ptr_q[AW-1:0];
          rd_ptr_d          = rd_ptr_q + CW'(1);
        end
      end

      dvrt_pkg::ST_ADV_RESULT: begin
        if (out_free_i) begin
          now         = last_q && (pending_q || chg_q);
          res_valid_o = 1'b1;
          if (found_q && hit_q) begin
            res_o.row_index     = 6'(first_row_q);
            res_o.row_node_id   = first_rec_q.dest_id;
            res_o.row_next_hop  = first_rec_q.gw_id;
            res_o.row_path_cost = first_rec_q.best_cost;
          end
          res_o.entry_changed   = chg_q;
          res_o.send_update_now = now;
          res_o.sender_unknown  = !found_q;
          res_o.last_result     = 1'b1;
          pending_d             = last_q ? 1'b0 : (pending_q || chg_q);
        end
      end

      dvrt_pkg::ST_WALK: begin
        if (walk_take) begin
          if (tick_q) begin
            // stale neighbor drops out before its row is reported
            if (r.missed > dvrt_pkg::MissLimit) begin
              r.best_cost   = dvrt_pkg::InfCost;
              r.hop_cost    = dvrt_pkg::InfCost;
              r.gw_id       = dvrt_pkg::InfCost;
              r.is_neighbor = 1'b0;
            end
            send = r.is_neighbor && (r.hop_cost != '0);
            if (send && r.missed != dvrt_pkg::MissMax) begin
              r.missed = r.missed + 2'd1;
            end
            ram_req_o.wr_en   = 1'b1;
            ram_req_o.wr_addr = dat_row_q;
            ram_req_o.wr_data = r;
          end
          res_valid_o         = 1'b1;
          res_o.row_index     = 6'(dat_row_q);
          res_o.row_node_id   = r.dest_id;
          res_o.row_next_hop  = r.gw_id;
          res_o.row_path_cost = r.best_cost;
          res_o.send_to_row   = send;
          res_o.last_result   = !more;
        end
        if (more && (!dv_q || out_free_i)) begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = rd_ptr_q[AW-1:0];
          dat_row_d         = rd_ptr_q[AW-1:0];
          rd_ptr_d          = rd_ptr_q + CW'(1);
          dv_d              = 1'b1;
        end else if (walk_take) begin
          dv_d = 1'b0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dvrt_pkg::ST_IDLE;
      rd_ptr_q  <= '0;
      dv_q      <= 1'b0;
      found_q   <= 1'b0;
      hit_q     <= 1'b0;
      chg_q     <= 1'b0;
      pending_q <= 1'b0;
      tick_q    <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_ptr_q  <= rd_ptr_d;
      dv_q      <= dv_d;
      found_q   <= found_d;
      hit_q     <= hit_d;
      chg_q     <= chg_d;
      pending_q <= pending_d;
      tick_q    <= tick_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_row_q   <= dat_row_d;
    snd_row_q   <= snd_row_d;
    sid_q       <= sid_d;
    nid_q       <= nid_d;
    cost_q      <= cost_d;
    sum_q       <= sum_d;
    first_row_q <= first_row_d;
    first_rec_q <= first_rec_d;
  end

  a_no_same_row_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.wr_en && ram_req_o.rd_en && ram_req_o.wr_addr == ram_req_o.rd_addr))
    else $error("table row read and written in the same cycle");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_free_i)
    else $error("result pushed while output register is full");

  a_relax_has_sender: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dvrt_pkg::ST_RELAX) |-> found_q)
    else $error("relaxation walk without a known sender");

  a_last_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && state_q == dvrt_pkg::ST_ADV_RESULT && last_q) |=> !pending_q)
    else $error("pending change survived the end of an advertisement");

endmodule

// ===== rtl/distance_vector_route_table_top.sv =====
// distance-vector route table: config register, output register, sequencer and table memory
//
// channels: in_ch takes one operation per beat (load, advert item, tick, dump),
// out_ch returns result beats, cfg_ch writes node_count (rows in use, clamped
// to the table size). all use valid/ready; a beat moves when both are high.
// the table sits in one single-port-read, single-port-write memory; relaxation
// and tick rows are read and then written back, search and dump rows are only read.
// a load returns nothing. an advert item searches rows in order for the sender,
// walks all n rows to relax the destination if the sender is found, and returns
// one beat. tick and dump walk the n rows at one row per cycle when out_ch
// keeps up and return n beats; the memory read port sets that pace.
// one item is in work at a time; in_ch.ready is high only between items.
// a finished beat waits in the output register; a stalled out_ch holds the
// walk at the current row, nothing is dropped.
// reset sets node_count to 1 and clears the pending-change flag; table rows
// are undefined until loaded and no clearing pass runs.
module distance_vector_route_table_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  dvrt_in_if.sink  in_ch,
  dvrt_out_if.source out_ch,
  dvrt_cfg_if.sink cfg_ch
);

  logic [6:0]         node_count_q;
  logic               out_valid_q;
  dvrt_pkg::res_t     res_q;
  logic               out_free;
  logic               res_valid;
  dvrt_pkg::res_t     res;
  dvrt_pkg::ram_req_t ram_req;
  dvrt_pkg::row_t     ram_rd_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 7'd1;
    end else if (cfg_ch.valid) begin
      node_count_q <= cfg_ch.node_count;
    end
  end

  assign out_free = !out_valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.row_index       = res_q.row_index;
  assign out_ch.row_node_id     = res_q.row_node_id;
  assign out_ch.row_next_hop    = res_q.row_next_hop;
  assign out_ch.row_path_cost   = res_q.row_path_cost;
  assign out_ch.send_to_row     = res_q.send_to_row;
  assign out_ch.entry_changed   = res_q.entry_changed;
  assign out_ch.send_update_now = res_q.send_update_now;
  assign out_ch.sender_unknown  = res_q.sender_unknown;
  assign out_ch.last_result     = res_q.last_result;

  dvrt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .node_count_i  (node_count_q),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .ram_req_o     (ram_req),
    .ram_rd_data_i (ram_rd_data)
  );

  dvrt_table_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd_data)
  );

endmodule

// ===== test/tb_distance_vector_route_table_top.sv =====
// self-checking testbench for the distance-vector route table: random and directed items
module tb_distance_vector_route_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 1000;
  localparam int SettleCycles = 8;
  localparam int TailCycles = 80;
  localparam int PrintCap = 100;

  typedef struct {
    dvrt_pkg::op_e op;
    logic [5:0]    entry_index;
    logic [15:0]   node_id;
    logic [15:0]   cost;
    logic [15:0]   sender_id;
    logic          adv_last;
    bit            drain;
  } route_item_t;

  logic clk_i;
  logic rst_ni;

  dvrt_in_if  in_ch();
  dvrt_out_if out_ch();
  dvrt_cfg_if cfg_ch();

  distance_vector_route_table_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted table contents
  logic [15:0] tbl_id   [dvrt_pkg::TableEntries];
  logic [15:0] tbl_link [dvrt_pkg::TableEntries];
  logic [15:0] tbl_path [dvrt_pkg::TableEntries];
  logic [15:0] tbl_hop  [dvrt_pkg::TableEntries];
  logic        tbl_nbr  [dvrt_pkg::TableEntries];
  logic [1:0]  tbl_miss [dvrt_pkg::TableEntries];
  logic        adv_pending;
  logic [6:0]  rows_cfg;

  dvrt_pkg::res_t expected_rows[$];
  route_item_t    item_q[$];
  route_item_t    cur_item;
  bit             item_live;

  // stimulus-side view of the table, kept so that no unloaded row is ever read
  logic [15:0] gen_ids    [dvrt_pkg::TableEntries];
  bit          gen_loaded [dvrt_pkg::TableEntries];
  int          gen_rows;
  logic [15:0] id_pool[12];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int beat_count;
  int quiet_cycles;

  int unsigned phase_rows[7] = '{32, 3, 127, 6, 64, 1, 9};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PrintCap) $display("error at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("beat %0d %s got %h expected %h", beat_count, name, got, want));
  endtask

  function automatic dvrt_pkg::res_t table_row(input int row, input logic send,
                                               input logic last);
    dvrt_pkg::res_t r;
    r = '0;
    r.row_index = 6'(row);
    r.row_node_id = tbl_id[row];
    r.row_next_hop = tbl_hop[row];
    r.row_path_cost = tbl_path[row];
    r.send_to_row = send;
    r.last_result = last;
    return r;
  endfunction

  task automatic predict_route_op(input route_item_t it);
    int                         n;
    int                         src;
    int                         first;
    bit                         found;
    bit                         hit;
    bit                         chg;
    logic                       send;
    logic [15:0]                via_id;
    logic [15:0]                sum;
    logic [16:0]                wide;
    logic [dvrt_pkg::AddrW-1:0] slot;
    dvrt_pkg::res_t             r;
    n = (rows_cfg > dvrt_pkg::TableEntries) ? dvrt_pkg::TableEntries : int'(rows_cfg);
    slot = dvrt_pkg::AddrW'(it.entry_index);
    case (it.op)
      dvrt_pkg::OP_LOAD: begin
        if (it.entry_index < dvrt_pkg::TableEntries) begin
          tbl_id[slot] = it.node_id;
          tbl_link[slot] = it.cost;
          tbl_path[slot] = it.cost;
          tbl_miss[slot] = 2'd0;
          tbl_hop[slot] = (it.cost == dvrt_pkg::InfCost) ? dvrt_pkg::InfCost : it.node_id;
          tbl_nbr[slot] = (it.cost != 16'd0) && (it.cost != dvrt_pkg::InfCost);
        end
      end
      dvrt_pkg::OP_ADVERT: begin
        found = 1'b0;
        hit = 1'b0;
        chg = 1'b0;
        src = 0;
        first = 0;
        for (int i = 0; i < n; i++) begin
          if (!found && tbl_id[i] == it.sender_id) begin
            found = 1'b1;
            src = i;
          end
        end
        if (found) begin
          via_id = tbl_id[src];
          wide = {1'b0, it.cost} + {1'b0, tbl_link[src]};
          sum = (wide > 17'h0FFFF) ? dvrt_pkg::InfCost : wide[15:0];
          tbl_miss[src] = 2'd0;
          for (int i = 0; i < n; i++) begin
            if (tbl_id[i] == it.node_id) begin
              if (!hit) begin
                hit = 1'b1;
                first = i;
              end
              // a route already through the sender follows it even when worse
              if (tbl_hop[i] == via_id) begin
                tbl_path[i] = sum;
              end else if (tbl_path[i] > sum) begin
                tbl_path[i] = sum;
                tbl_hop[i] = via_id;
                chg = 1'b1;
              end
            end
          end
          if (chg) adv_pending = 1'b1;
        end
        r = (found && hit) ? table_row(first, 1'b0, 1'b1) : dvrt_pkg::res_t'('0);
        r.entry_changed = chg;
        r.send_update_now = it.adv_last & adv_pending;
        r.sender_unknown = !found;
        r.last_result = 1'b1;
        if (it.adv_last) adv_pending = 1'b0;
        expected_rows.push_back(r);
      end
      dvrt_pkg::OP_TICK: begin
        for (int i = 0; i < n; i++) begin
          if (tbl_miss[i] > dvrt_pkg::MissLimit) begin
            tbl_path[i] = dvrt_pkg::InfCost;
            tbl_link[i] = dvrt_pkg::InfCost;
            tbl_hop[i] = dvrt_pkg::InfCost;
            tbl_nbr[i] = 1'b0;
          end
          send = tbl_nbr[i] && (tbl_link[i] != 16'd0);
          if (send && tbl_miss[i] != dvrt_pkg::MissMax) tbl_miss[i] = tbl_miss[i] + 2'd1;
          expected_rows.push_back(table_row(i, send, i == n - 1));
        end
      end
      default: begin
        for (int i = 0; i < n; i++) expected_rows.push_back(table_row(i, 1'b0, i == n - 1));
      end
    endcase
  endtask

  task automatic check_result_beat();
    dvrt_pkg::res_t got;
    dvrt_pkg::res_t want;
    got = {out_ch.row_index, out_ch.row_node_id, out_ch.row_next_hop, out_ch.row_path_cost,
           out_ch.send_to_row, out_ch.entry_changed, out_ch.send_update_now,
           out_ch.sender_unknown, out_ch.last_result};
    if (expected_rows.size() == 0) begin
      report_error($sformatf("beat %0d arrived with nothing expected", beat_count));
    end else begin
      want = expected_rows.pop_front();
      check_field("row_index", 16'(got.row_index), 16'(want.row_index));
      check_field("row_node_id", got.row_node_id, want.row_node_id);
      check_field("row_next_hop", got.row_next_hop, want.row_next_hop);
      check_field("row_path_cost", got.row_path_cost, want.row_path_cost);
      check_field("send_to_row", 16'(got.send_to_row), 16'(want.send_to_row));
      check_field("entry_changed", 16'(got.entry_changed), 16'(want.entry_changed));
      check_field("send_update_now", 16'(got.send_update_now), 16'(want.send_update_now));
      check_field("sender_unknown", 16'(got.sender_unknown), 16'(want.sender_unknown));
      check_field("last_result", 16'(got.last_result), 16'(want.last_result));
    end
    beat_count++;
  endtask

  // monitor: sample every channel at the rising edge
  always @(posedge clk_i) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        check_result_beat();
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_route_op(cur_item);
        item_live = 1'b0;
        moved = 1'b1;
      end
      if (cfg_ch.valid && cfg_ch.ready) moved = 1'b1;
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // input driver: valid holds until the beat is taken
  always @(negedge clk_i) begin
    if (rst_ni && !item_live && item_q.size() > 0 &&
        (!item_q[0].drain || expected_rows.size() == 0) &&
        $urandom_range(99) >= send_idle_pct) begin
      cur_item = item_q.pop_front();
      item_live = 1'b1;
      in_ch.valid <= 1'b1;
      in_ch.operation <= cur_item.op;
      in_ch.entry_index <= cur_item.entry_index;
      in_ch.node_id <= cur_item.node_id;
      in_ch.cost <= cur_item.cost;
      in_ch.sender_id <= cur_item.sender_id;
      in_ch.last_in_advert <= cur_item.adv_last;
    end else if (!item_live) begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("watchdog: no beat moved for %0d cycles", QuietLimit);
    $display("** distance_vector_route_table_top: FAILED **");
    $finish;
  end

  task automatic write_node_count(input logic [6:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.node_count <= value;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    rows_cfg = value;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_until_drained(input int settle);
    while (item_q.size() != 0 || item_live || expected_rows.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic queue_item(input dvrt_pkg::op_e op, input logic [5:0] entry_index,
                            input logic [15:0] node_id, input logic [15:0] cost,
                            input logic [15:0] sender_id, input logic adv_last,
                            input bit drain);
    route_item_t                it;
    logic [dvrt_pkg::AddrW-1:0] slot;
    it.op = op;
    it.entry_index = entry_index;
    it.node_id = node_id;
    it.cost = cost;
    it.sender_id = sender_id;
    it.adv_last = adv_last;
    it.drain = drain;
    slot = dvrt_pkg::AddrW'(entry_index);
    if (op == dvrt_pkg::OP_LOAD && entry_index < dvrt_pkg::TableEntries) begin
      gen_ids[slot] = node_id;
      gen_loaded[slot] = 1'b1;
    end
    item_q.push_back(it);
  endtask

  function automatic int live_rows();
    return (gen_rows > dvrt_pkg::TableEntries) ? dvrt_pkg::TableEntries : gen_rows;
  endfunction

  function automatic logic [15:0] pick_id();
    return ($urandom_range(99) < 75) ? id_pool[$urandom_range(0, 11)] : 16'($urandom);
  endfunction

  function automatic logic [15:0] table_id();
    return gen_ids[$urandom_range(0, live_rows() - 1)];
  endfunction

  function automatic logic [15:0] pick_load_cost();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 20) return dvrt_pkg::InfCost;
    if (r < 70) return 16'($urandom_range(1, 30));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_advert_cost();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(0, 40));
    if (r < 85) return 16'($urandom);
    if (r < 95) return dvrt_pkg::InfCost;
    return 16'($urandom_range(16'hFF00, 16'hFFFE));
  endfunction

  task automatic ensure_rows_loaded();
    for (int i = 0; i < live_rows(); i++) begin
      if (!gen_loaded[i])
        queue_item(dvrt_pkg::OP_LOAD, 6'(i), pick_id(), pick_load_cost(), 16'($urandom),
                   1'($urandom), 1'b0);
    end
  endtask

  task automatic queue_random_phase(input int count);
    int          made;
    int          kind;
    int          len;
    logic [15:0] sender;
    logic        last;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        queue_item(dvrt_pkg::OP_LOAD,
                   ($urandom_range(99) < 85) ? 6'($urandom_range(0, live_rows() - 1))
                                             : 6'($urandom_range(0, 63)),
                   pick_id(), pick_load_cost(), 16'($urandom), 1'($urandom), 1'b0);
        made++;
      end else if (kind < 60) begin
        // one advertisement from a sender in the table, now and then a stranger or no closing item
        len = $urandom_range(1, 4);
        sender = ($urandom_range(99) < 85) ? table_id() : pick_id();
        for (int k = 0; k < len; k++) begin
          last = (k == len - 1) ? ($urandom_range(99) < 90) : ($urandom_range(99) < 5);
          queue_item(dvrt_pkg::OP_ADVERT, 6'($urandom),
                     ($urandom_range(99) < 80) ? table_id() : pick_id(),
                     pick_advert_cost(), sender, last, $urandom_range(99) < 3);
          made++;
        end
      end else begin
        queue_item((kind < 82) ? dvrt_pkg::OP_TICK : dvrt_pkg::OP_DUMP, 6'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                   $urandom_range(99) < 3);
        made++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = dvrt_pkg::OP_LOAD;
    in_ch.entry_index = '0;
    in_ch.node_id = '0;
    in_ch.cost = '0;
    in_ch.sender_id = '0;
    in_ch.last_in_advert = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.node_count = '0;
    item_live = 1'b0;
    adv_pending = 1'b0;
    rows_cfg = 7'd1;
    error_count = 0;
    beat_count = 0;
    quiet_cycles = 0;
    gen_rows = 1;
    foreach (gen_loaded[i]) gen_loaded[i] = 1'b0;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    id_pool[2] = 16'h5555;
    id_pool[3] = 16'hAAAA;
    for (int i = 4; i < 12; i++) id_pool[i] = 16'($urandom);
    send_idle_pct = 37;
    recv_idle_pct = 60;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // one row after reset: self entry, unknown sender, ignored loads
    queue_item(dvrt_pkg::OP_LOAD, 6'd0, 16'h0001, 16'd0, 16'd0, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_DUMP, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_TICK, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_ADVERT, 6'd0, 16'h0001, 16'd7, 16'hBEEF, 1'b1, 1'b0);
    queue_item(dvrt_pkg::OP_ADVERT, 6'd0, 16'h0001, 16'd5, 16'h0001, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_LOAD, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    queue_item(dvrt_pkg::OP_LOAD, 6'd32, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    queue_item(dvrt_pkg::OP_ADVERT, 6'd0, 16'h0001, 16'd5, 16'h1234, 1'b1, 1'b0);
    wait_until_drained(SettleCycles);

    // empty table
    write_node_count(7'd0);
    gen_rows = 0;
    queue_item(dvrt_pkg::OP_TICK, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_DUMP, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_ADVERT, 6'd0, 16'h0001, 16'd1, 16'h0001, 1'b1, 1'b0);
    wait_until_drained(SettleCycles);

    // neighbor, unreachable row, saturation, same next hop, duplicate ids, expiry
    write_node_count(7'd4);
    gen_rows = 4;
    queue_item(dvrt_pkg::OP_LOAD, 6'd1, 16'h00A1, 16'd3, 16'd0, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_LOAD, 6'd2, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_LOAD, 6'd3, 16'h0000, 16'hFFFE, 16'd0, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_ADVERT, 6'd0, 16'hFFFF, 16'd10, 16'h00A1, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_ADVERT, 6'd0, 16'h0000, 16'hFFFF, 16'h00A1, 1'b1, 1'b0);
    queue_item(dvrt_pkg::OP_ADVERT, 6'd0, 16'hFFFF, 16'd100, 16'h00A1, 1'b1, 1'b0);
    queue_item(dvrt_pkg::OP_LOAD, 6'd0, 16'hFFFF, 16'd0, 16'd0, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_ADVERT, 6'd0, 16'hFFFF, 16'd1, 16'h00A1, 1'b1, 1'b0);
    queue_item(dvrt_pkg::OP_TICK, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
    repeat (3) queue_item(dvrt_pkg::OP_TICK, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    queue_item(dvrt_pkg::OP_DUMP, 6'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    wait_until_drained(SettleCycles);

    for (int k = 0; k < 7; k++) begin
      if (k < 2) begin
        send_idle_pct = 37;
        recv_idle_pct = 60;
      end else if (k < 5) begin
        send_idle_pct = 60;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_node_count(7'(phase_rows[k]));
      gen_rows = phase_rows[k];
      ensure_rows_loaded();
      queue_random_phase(30);
      wait_until_drained((k == 6) ? TailCycles : SettleCycles);
    end

    if (expected_rows.size() != 0)
      report_error($sformatf("%0d expected beats never arrived", expected_rows.size()));
    if (error_count == 0) begin
      $display("** distance_vector_route_table_top: PASSED **");
    end else begin
      $display("** distance_vector_route_table_top: FAILED **");
    end
    $finish;
  end

endmodule
